// ===== src/streaming_voxel_accumulator_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the streaming voxel accumulator
// Concurrent checks that vanish in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef STREAMING_VOXEL_ACCUMULATOR_UNIT_DEFINES_SVH
`define STREAMING_VOXEL_ACCUMULATOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// check with reset disable
`define SVAU_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check without reset disable
`define SVAU_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SVAU_ASSERT(lbl, clk, rst, prop, msg)
`define SVAU_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// ===== src/svau_pkg.sv =====
// ----------------------------------------------------------------------------
// svau_pkg
// Types and codes shared by the voxel accumulator modules.
// ----------------------------------------------------------------------------
package svau_pkg;

   // widest cell key (three 21-bit axes)
   localparam int KEY_W_MAX = 63;
   // coordinate times zero-extended inverse size
   localparam int PROD_W    = 57;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 24;

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_FULL   = 2'd1,
      STAT_SAT    = 2'd2,
      STAT_UNUSED = 2'd3
   } status_type;

   localparam logic [CSR_IDX_W-1:0] CSR_INV_VOXEL_SIZE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AVERAGE_MODE   = 1'd1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_UPD,
      S_MISS,
      S_RD,
      S_DIV_GO,
      S_DIV_RUN,
      S_RESP
   } state_type;

   typedef struct packed {
      op_type             operation;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
      logic [7:0]         alpha;
      logic [9:0]         read_index;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [9:0]         voxel_index;
      logic               was_new;
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic [7:0]         out_red;
      logic [7:0]         out_green;
      logic [7:0]         out_blue;
      logic [7:0]         out_alpha;
      logic [10:0]        occupied_voxels;
      logic [31:0]        seen_points;
   } rsp_type;

   // classified word handed from front to back
   typedef struct packed {
      req_type                req;
      logic [KEY_W_MAX-1:0]   key;
   } cmd_type;

endpackage

// ===== src/streaming_voxel_accumulator_unit.sv =====
// ----------------------------------------------------------------------------
// streaming_voxel_accumulator_unit
// Streaming voxel grid with per-cell centroid sums, top level.
// ----------------------------------------------------------------------------
// An add word is quantized in the front and queued; the back end then
// scans the key memory one entry per cycle over the used entries. A read in
// first-point mode returns the stored first point; in averaging mode seven
// divisions by the count run one quotient bit per cycle in a shared divider.
// Clear and no-op words go straight to the result.
// A stalled result word holds the back end until it leaves.
// The queue and result register let the front take words while the back works.
module streaming_voxel_accumulator_unit #(
   parameter int MAX_VOXELS = 1024,
   parameter int COUNT_BITS = 16,
   parameter int CELL_BITS  = 21
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  svau_pkg::req_type                   req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output svau_pkg::rsp_type                   rsp_word,
   input  logic                                csr_we,
   input  logic [svau_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [svau_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import svau_pkg::*;

   localparam int CMD_W = $bits(cmd_type);

   logic [23:0]      inv_voxel_size_ff;
   logic             average_mode_ff;
   logic             push;
   cmd_type          push_data;
   logic             full;
   logic             pop;
   logic [CMD_W-1:0] head;
   logic             empty;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         inv_voxel_size_ff <= 24'd1310720;
         average_mode_ff   <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_INV_VOXEL_SIZE: inv_voxel_size_ff <= csr_wdata;
            CSR_AVERAGE_MODE:   average_mode_ff   <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   svau_front #(.CELL_BITS(CELL_BITS)) u_front (
      .clock          (clock),
      .reset          (reset),
      .inv_voxel_size (inv_voxel_size_ff),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_word       (req_word),
      .push           (push),
      .push_data      (push_data),
      .full           (full)
   );

   svau_fifo #(.WIDTH(CMD_W)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .head      (head),
      .empty     (empty)
   );

   svau_back #(
      .MAX_VOXELS (MAX_VOXELS),
      .COUNT_BITS (COUNT_BITS),
      .CELL_BITS  (CELL_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .average_mode (average_mode_ff),
      .q_empty      (empty),
      .q_pop        (pop),
      .q_data       (cmd_type'(head)),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_word     (rsp_word)
   );

endmodule

// ===== src/svau_ram.sv =====
// ----------------------------------------------------------------------------
// svau_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module svau_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/svau_fifo.sv =====
// ----------------------------------------------------------------------------
// svau_fifo
// Two-entry queue between the classify front and the table back end.
// ----------------------------------------------------------------------------
module svau_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] head,
   output logic             empty
);

   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head  = slot_ff[rd_ptr_ff];

endmodule

// ===== src/svau_div.sv =====
// ----------------------------------------------------------------------------
// svau_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module svau_div #(
   parameter int DW = 49,
   parameter int VW = 17
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient
);

   localparam int CW = $clog2(DW + 1);

   logic          busy_ff;
   logic          done_ff;
   logic [CW-1:0] cnt_ff;
   logic [DW-1:0] dvd_ff;
   logic [VW-1:0] dvs_ff;
   logic [VW-1:0] rem_ff;
   logic [VW:0]   rem_sh;
   logic [VW:0]   diff;
   logic          qbit;

   // trial subtract
   always_comb begin
      rem_sh = {rem_ff, dvd_ff[DW-1]};
      diff   = rem_sh - {1'b0, dvs_ff};
      qbit   = ~diff[VW];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(DW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // quotient shifts into the dividend register
   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         dvs_ff <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= qbit ? diff[VW-1:0] : rem_sh[VW-1:0];
         dvd_ff <= {dvd_ff[DW-2:0], qbit};
      end
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

// ===== src/svau_front.sv =====
// ----------------------------------------------------------------------------
// svau_front
// Accepts request words, quantizes the point to a cell key, queues the word.
// ----------------------------------------------------------------------------
module svau_front #(
   parameter int CELL_BITS = 21
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [23:0]        inv_voxel_size,
   input  logic               req_valid,
   output logic               req_stall,
   input  svau_pkg::req_type  req_word,
   output logic               push,
   output svau_pkg::cmd_type  push_data,
   input  logic               full
);
   import svau_pkg::*;

   localparam int QW = PROD_W - 32;
   localparam logic signed [QW-1:0] C_HI = QW'((1 << (CELL_BITS - 1)) - 1);
   localparam logic signed [QW-1:0] C_LO = -C_HI - QW'(1);

   logic                     s1_valid_ff, s1_valid_in;
   req_type                  s1_req_ff;
   logic signed [PROD_W-1:0] prod_ff [3];
   logic signed [PROD_W-1:0] prod_in [3];
   logic signed [QW-1:0]     cell_q [3];
   logic [CELL_BITS-1:0]     cell_idx [3];
   logic                     accept;

   assign req_stall = s1_valid_ff & full;
   assign accept    = req_valid & ~req_stall;
   assign push      = s1_valid_ff & ~full;

   always_comb begin
      s1_valid_in = accept | (s1_valid_ff & ~push);
   end

   // scale each axis by the inverse voxel size
   always_comb begin
      prod_in[0] = req_word.pos_x * $signed({1'b0, inv_voxel_size});
      prod_in[1] = req_word.pos_y * $signed({1'b0, inv_voxel_size});
      prod_in[2] = req_word.pos_z * $signed({1'b0, inv_voxel_size});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff <= req_word;
         for (int a = 0; a < 3; a++) begin
            prod_ff[a] <= prod_in[a];
         end
      end
   end

   // floor by dropping the fraction, then clamp to the cell range
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         cell_q[a] = prod_ff[a][PROD_W-1:32];
         if (cell_q[a] > C_HI) begin
            cell_idx[a] = C_HI[CELL_BITS-1:0];
         end else if (cell_q[a] < C_LO) begin
            cell_idx[a] = C_LO[CELL_BITS-1:0];
         end else begin
            cell_idx[a] = cell_q[a][CELL_BITS-1:0];
         end
      end
   end

   always_comb begin
      push_data.req = s1_req_ff;
      push_data.key = KEY_W_MAX'({cell_idx[0], cell_idx[1], cell_idx[2]});
   end

endmodule

// ===== src/svau_back.sv =====
// ----------------------------------------------------------------------------
// svau_back
// Table engine: key scan, entry update or allocate, reads with or without averaging.
// ----------------------------------------------------------------------------
`include "streaming_voxel_accumulator_unit_defines.svh"

module svau_back #(
   parameter int MAX_VOXELS = 1024,
   parameter int COUNT_BITS = 16,
   parameter int CELL_BITS  = 21
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              average_mode,
   input  logic              q_empty,
   output logic              q_pop,
   input  svau_pkg::cmd_type q_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output svau_pkg::rsp_type rsp_word
);
   import svau_pkg::*;

   localparam int IDX_W   = $clog2(MAX_VOXELS);
   localparam int UW      = $clog2(MAX_VOXELS + 1);
   localparam int KW      = 3 * CELL_BITS;
   localparam int CB      = COUNT_BITS;
   localparam int SPW     = 32 + COUNT_BITS;
   localparam int SCW     = 8 + COUNT_BITS;
   localparam int CMPW    = (UW > 11) ? UW : 11;
   localparam int OFF_SC  = 3 * SPW;
   localparam int OFF_CNT = OFF_SC + 4 * SCW;
   localparam int OFF_F   = OFF_CNT + CB;
   localparam int ENTRY_W = OFF_F + 128;
   localparam int DW      = SPW + 1;
   localparam int VW      = CB + 1;
   localparam logic [2:0] LAST_SEL = 3'd6;
   localparam logic [2:0] FIRST_COL_SEL = 3'd3;

   state_type          state_ff, state_in;
   logic [UW-1:0]      used_ff;
   logic [31:0]        seen_ff;
   logic [IDX_W-1:0]   scan_ff;
   cmd_type            cmd_ff;
   status_type         res_status_ff;
   logic [CMPW-1:0]    res_vidx_ff;
   logic               res_new_ff;
   logic [31:0]        res_pos_ff [3];
   logic [7:0]         res_col_ff [4];
   logic [ENTRY_W-1:0] ent_ff;
   logic [2:0]         sel_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_word_ff;

   logic               key_wr_en;
   logic [IDX_W-1:0]   key_rd_addr;
   logic [KW-1:0]      key_rd_data;
   logic               ent_wr_en;
   logic [IDX_W-1:0]   ent_wr_addr;
   logic [ENTRY_W-1:0] ent_wr_data;
   logic [IDX_W-1:0]   ent_rd_addr;
   logic [ENTRY_W-1:0] ent_rd_data;
   logic [ENTRY_W-1:0] new_entry;
   logic [ENTRY_W-1:0] upd_entry;

   logic               div_start;
   logic               div_done;
   logic [DW-1:0]      div_dividend;
   logic [VW-1:0]      div_divisor;
   logic [DW-1:0]      div_q;

   logic [CMPW-1:0]    rdx_ext;
   logic               rd_in_range;
   logic               key_match;
   logic               scan_last;
   logic               table_full;
   logic               cnt_max;
   logic               slot_free;
   logic [CB-1:0]      rd_cnt;
   logic [CB-1:0]      ent_cnt;
   logic signed [SPW-1:0] sum_pos [3];
   logic [SCW-1:0]     sum_col [4];
   logic [1:0]         pos_idx;
   logic [1:0]         col_idx;
   logic [2:0]         col_sel;
   logic [SPW-1:0]     pos_mag;
   logic [31:0]        pos_q;
   logic [31:0]        pin [3];
   logic [7:0]         cin [4];

   // status terms
   always_comb begin
      rdx_ext     = CMPW'(q_data.req.read_index);
      rd_in_range = rdx_ext < CMPW'(used_ff);
      key_match   = key_rd_data == cmd_ff.key[KW-1:0];
      scan_last   = (UW'(scan_ff) + UW'(1)) == used_ff;
      table_full  = used_ff == UW'(MAX_VOXELS);
      rd_cnt      = ent_rd_data[OFF_CNT +: CB];
      cnt_max     = rd_cnt == {CB{1'b1}};
      slot_free   = ~rsp_valid_ff | ~rsp_stall;
      pin[0] = cmd_ff.req.pos_x;
      pin[1] = cmd_ff.req.pos_y;
      pin[2] = cmd_ff.req.pos_z;
      cin[0] = cmd_ff.req.red;
      cin[1] = cmd_ff.req.green;
      cin[2] = cmd_ff.req.blue;
      cin[3] = cmd_ff.req.alpha;
   end

   // fresh entry and accumulated entry
   always_comb begin
      new_entry = '0;
      upd_entry = ent_rd_data;
      for (int a = 0; a < 3; a++) begin
         new_entry[a*SPW +: SPW] = SPW'($signed(pin[a]));
         upd_entry[a*SPW +: SPW] = ent_rd_data[a*SPW +: SPW] + SPW'($signed(pin[a]));
         new_entry[OFF_F + a*32 +: 32] = pin[a];
      end
      for (int c = 0; c < 4; c++) begin
         new_entry[OFF_SC + c*SCW +: SCW] = SCW'(cin[c]);
         upd_entry[OFF_SC + c*SCW +: SCW] = ent_rd_data[OFF_SC + c*SCW +: SCW] + SCW'(cin[c]);
         new_entry[OFF_F + 96 + c*8 +: 8] = cin[c];
      end
      new_entry[OFF_CNT +: CB] = CB'(1);
      upd_entry[OFF_CNT +: CB] = rd_cnt + CB'(1);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               unique case (q_data.req.operation)
                  OP_ADD:  state_in = (used_ff == '0) ? S_MISS : S_SCAN;
                  OP_READ: state_in = rd_in_range ? S_RD : S_RESP;
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_SCAN: begin
            if (key_match) begin
               state_in = S_UPD;
            end else if (scan_last) begin
               state_in = S_MISS;
            end
         end
         S_UPD:     state_in = S_RESP;
         S_MISS:    state_in = S_RESP;
         S_RD:      state_in = average_mode ? S_DIV_GO : S_RESP;
         S_DIV_GO:  state_in = S_DIV_RUN;
         S_DIV_RUN: begin
            if (div_done) begin
               state_in = (sel_ff == LAST_SEL) ? S_RESP : S_DIV_GO;
            end
         end
         S_RESP: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default:   state_in = S_IDLE;
      endcase
   end

   // memory and unit controls
   always_comb begin
      q_pop       = (state_ff == S_IDLE) & ~q_empty;
      key_wr_en   = (state_ff == S_MISS) & ~table_full;
      key_rd_addr = (state_ff == S_SCAN) ? IDX_W'(UW'(scan_ff) + UW'(1)) : '0;
      ent_rd_addr = (state_ff == S_SCAN) ? scan_ff : rdx_ext[IDX_W-1:0];
      ent_wr_en   = ((state_ff == S_MISS) & ~table_full) | ((state_ff == S_UPD) & ~cnt_max);
      ent_wr_addr = (state_ff == S_MISS) ? used_ff[IDX_W-1:0] : scan_ff;
      ent_wr_data = (state_ff == S_MISS) ? new_entry : upd_entry;
      div_start   = state_ff == S_DIV_GO;
   end

   // divider operands: three positions then four colors
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         sum_pos[a] = ent_ff[a*SPW +: SPW];
      end
      for (int c = 0; c < 4; c++) begin
         sum_col[c] = ent_ff[OFF_SC + c*SCW +: SCW];
      end
      ent_cnt = ent_ff[OFF_CNT +: CB];
      col_sel = sel_ff - FIRST_COL_SEL;
      pos_idx = sel_ff[1:0];
      col_idx = col_sel[1:0];
      pos_mag = sum_pos[pos_idx][SPW-1] ? SPW'(-sum_pos[pos_idx]) : SPW'(sum_pos[pos_idx]);
      if (sel_ff < FIRST_COL_SEL) begin
         div_dividend = DW'(pos_mag) + DW'(ent_cnt >> 1);
         div_divisor  = VW'(ent_cnt);
      end else begin
         div_dividend = DW'({sum_col[col_idx], 1'b0}) + DW'(ent_cnt);
         div_divisor  = {ent_cnt, 1'b0};
      end
      pos_q = sum_pos[pos_idx][SPW-1] ? -div_q[31:0] : div_q[31:0];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (q_pop && q_data.req.operation == OP_ADD && seen_ff != '1) begin
            seen_ff <= seen_ff + 32'd1;
         end
         if (q_pop && q_data.req.operation == OP_CLEAR) begin
            used_ff <= '0;
            seen_ff <= '0;
         end
         if (key_wr_en) begin
            used_ff <= used_ff + UW'(1);
         end
         if (state_ff == S_RESP && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            cmd_ff        <= q_data;
            scan_ff       <= '0;
            sel_ff        <= '0;
            res_status_ff <= STAT_OK;
            res_vidx_ff   <= '0;
            res_new_ff    <= 1'b0;
            for (int a = 0; a < 3; a++) res_pos_ff[a] <= '0;
            for (int c = 0; c < 4; c++) res_col_ff[c] <= '0;
            if (q_data.req.operation == OP_READ) begin
               res_vidx_ff <= rdx_ext;
               if (!rd_in_range) res_status_ff <= STAT_UNUSED;
            end
         end
         S_SCAN: begin
            if (!key_match && !scan_last) scan_ff <= IDX_W'(UW'(scan_ff) + UW'(1));
         end
         S_UPD: begin
            res_vidx_ff <= CMPW'(scan_ff);
            if (cnt_max) res_status_ff <= STAT_SAT;
         end
         S_MISS: begin
            if (table_full) begin
               res_status_ff <= STAT_FULL;
            end else begin
               res_vidx_ff <= CMPW'(used_ff);
               res_new_ff  <= 1'b1;
            end
         end
         S_RD: begin
            ent_ff <= ent_rd_data;
            if (!average_mode) begin
               for (int a = 0; a < 3; a++) res_pos_ff[a] <= ent_rd_data[OFF_F + a*32 +: 32];
               for (int c = 0; c < 4; c++) res_col_ff[c] <= ent_rd_data[OFF_F + 96 + c*8 +: 8];
            end
         end
         S_DIV_RUN: begin
            if (div_done) begin
               if (sel_ff < FIRST_COL_SEL) begin
                  res_pos_ff[pos_idx] <= pos_q;
               end else begin
                  res_col_ff[col_idx] <= div_q[7:0];
               end
               sel_ff <= sel_ff + 3'd1;
            end
         end
         default: begin
         end
      endcase
   end

   // result word register
   always_ff @(posedge clock) begin
      if (state_ff == S_RESP && slot_free) begin
         rsp_word_ff.status          <= res_status_ff;
         rsp_word_ff.voxel_index     <= res_vidx_ff[9:0];
         rsp_word_ff.was_new         <= res_new_ff;
         rsp_word_ff.out_x           <= res_pos_ff[0];
         rsp_word_ff.out_y           <= res_pos_ff[1];
         rsp_word_ff.out_z           <= res_pos_ff[2];
         rsp_word_ff.out_red         <= res_col_ff[0];
         rsp_word_ff.out_green       <= res_col_ff[1];
         rsp_word_ff.out_blue        <= res_col_ff[2];
         rsp_word_ff.out_alpha       <= res_col_ff[3];
         rsp_word_ff.occupied_voxels <= 11'(CMPW'(used_ff));
         rsp_word_ff.seen_points     <= seen_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   svau_ram #(.WIDTH(KW), .DEPTH(MAX_VOXELS)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (used_ff[IDX_W-1:0]),
      .wr_data (cmd_ff.key[KW-1:0]),
      .rd_addr (key_rd_addr),
      .rd_data (key_rd_data)
   );

   svau_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_VOXELS)) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_wr_en),
      .wr_addr (ent_wr_addr),
      .wr_data (ent_wr_data),
      .rd_addr (ent_rd_addr),
      .rd_data (ent_rd_data)
   );

   svau_div #(.DW(DW), .VW(VW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   `SVAU_ASSERT(a_used_bound, clock, reset, used_ff <= UW'(MAX_VOXELS), "fill count past table size")
   `SVAU_ASSERT(a_scan_range, clock, reset, (state_ff == S_SCAN) |-> (UW'(scan_ff) < used_ff), "scan past used entries")
   `SVAU_ASSERT(a_new_ok, clock, reset, (rsp_valid_ff && rsp_word_ff.was_new) |-> (rsp_word_ff.status == STAT_OK), "new entry on failed add")

endmodule
